// ----- hw/rtl/buddy_page_allocator_assert.svh -----
// Assertion macros used by the buddy page allocator datapath (bpa_dp).
// No dependencies; included inside module bodies.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BPA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/bpa_pkg.sv -----
// Buddy page allocator package: sizes, controller states, datapath commands.
// No dependencies.
package bpa_pkg;

    localparam int LEVELS      = 7;
    localparam int TOTAL_PAGES = 16384;
    localparam int WORD_W      = 64;
    localparam int POS_W       = 6;
    localparam int WRD_W       = 8;      // word index within level 0
    localparam int LVL_W       = 3;
    localparam int PAGE_W      = 14;
    localparam int CNT_W       = 7;
    localparam int FREE_W      = 15;
    localparam int ADDR_W      = 9;
    localparam int L0_WORDS    = TOTAL_PAGES / WORD_W;
    localparam int MEM_WORDS   = 2 * L0_WORDS - (2 * L0_WORDS >> LEVELS);
    localparam int MAX_BLOCK   = 1 << (LEVELS - 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_START, ST_FAIL, ST_DONE,
        ST_SCAN_RD, ST_SCAN_CHK, ST_PAR_RD, ST_PAR_CHK, ST_BUD_RD, ST_BUD_WR,
        ST_RT_CHK, ST_RT_RD, ST_RT_WR,
        ST_FCLR_RD, ST_FCLR_WR, ST_MRG_RD, ST_MRG_WR, ST_MP_RD, ST_MP_WR, ST_MRG_STEP
    } state_t;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_START, CMD_FAIL, CMD_OUT,
        CMD_SCAN_RD, CMD_SCAN_NEXT, CMD_FOUND, CMD_PAR_RD, CMD_PAR_SET,
        CMD_BUD_RD, CMD_BUD_WR, CMD_RT_HIGH, CMD_RT_RD, CMD_RT_WR,
        CMD_FCLR_RD, CMD_FCLR_WR, CMD_MRG_RD, CMD_MRG_WR, CMD_MP_RD, CMD_MP_WR,
        CMD_MRG_STEP
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic zero_cnt;
        logic too_big;
        logic is_free;
        logic word_full;
        logic last_word;
        logic top_lvl;
        logic par_bit;
        logic rt_done;
        logic rt_low;
        logic fclr_last;
        logic pair_any;
        logic mrg_last;
        logic mrg_top;
        logic out_free;
    } dp_status_t;

    // word offset of level lvl in the bitmap memory
    function automatic logic [ADDR_W-1:0] lvl_base(input logic [LVL_W-1:0] lvl);
        logic [ADDR_W+1:0] full;
        full = (ADDR_W + 2)'(2 * L0_WORDS);
        return ADDR_W'(full - (full >> lvl));
    endfunction

    // rounded-up log2 of a page count
    function automatic logic [LVL_W-1:0] ceil_log2(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] m;
        logic [LVL_W-1:0] r;
        m = cnt - CNT_W'(1);
        r = '0;
        for (int i = 0; i < CNT_W; i++)
        begin
            if ((m >> i) != '0)
                r = LVL_W'(i + 1);
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/buddy_page_allocator.sv -----
// Buddy page allocator top level: stream ports, controller and datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp.
//
//  channel | direction | tdata (low bit first)                 | tuser
//  s_*     | in        | page_count[6:0], page_number[13:0]    | operation
//  m_*     | out       | start_page[13:0], free_pages[14:0]    | ok
//
// Sequence: a rejected request goes straight to its result; an allocation scans one
//   64-bit bitmap word at a time (up to 508 words), then checks the parent (not at the
//   top level) and releases the unneeded tail step by step; a free clears each touched
//   level-0 word and then merges free buddy pairs upward word by word.
// The single-port bitmap memory (one read-modify-write at a time) sets the rate.
// Reset: a clearing pass writes all 508 bitmap words; no request is taken then.
// A finished result waits in the output register while the next request is taken.
module buddy_page_allocator (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // page_count[6:0], page_number[20:7], zero pad
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // start_page[13:0], free_pages[28:14], zero pad
    output logic        m_tuser    // ok
);
    import bpa_pkg::*;

    dp_cmd_t           cmd;
    dp_status_t        st;
    logic [PAGE_W-1:0] res_start;
    logic [FREE_W-1:0] res_free;

    // sequencer: one request at a time
    bpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    // bitmaps, counters and the output register
    bpa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .st        (st),
        .in_op     (s_tuser),
        .in_cnt    (s_tdata[CNT_W-1:0]),
        .in_page   (s_tdata[CNT_W+PAGE_W-1:CNT_W]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_start (res_start),
        .out_ok    (m_tuser),
        .out_free  (res_free)
    );

    assign m_tdata = {3'b000, res_free, res_start};

endmodule

// ----- hw/rtl/bpa_ctrl.sv -----
// Buddy page allocator controller: sequences the datapath per request.
// Depends on bpa_pkg.
module bpa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bpa_pkg::dp_status_t  st,
    output bpa_pkg::dp_cmd_t     cmd
);
    import bpa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = CMD_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd = CMD_CLEAR;
                if (st.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (st.zero_cnt || st.too_big)
                    state_next = ST_FAIL;
                else
                begin
                    cmd        = CMD_START;
                    state_next = st.is_free ? ST_FCLR_RD : ST_SCAN_RD;
                end
            end
            ST_FAIL:
            begin
                cmd        = CMD_FAIL;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd        = CMD_OUT;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                cmd        = CMD_SCAN_RD;
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK:
            begin
                if (!st.word_full)
                begin
                    cmd        = CMD_FOUND;
                    state_next = st.top_lvl ? ST_RT_CHK : ST_PAR_RD;
                end
                else if (st.last_word && st.top_lvl)
                    state_next = ST_FAIL;
                else
                begin
                    cmd        = CMD_SCAN_NEXT;
                    state_next = ST_SCAN_RD;
                end
            end
            ST_PAR_RD:
            begin
                cmd        = CMD_PAR_RD;
                state_next = ST_PAR_CHK;
            end
            ST_PAR_CHK:
            begin
                if (!st.par_bit)
                begin
                    cmd        = CMD_PAR_SET;
                    state_next = ST_BUD_RD;
                end
                else
                    state_next = ST_RT_CHK;
            end
            ST_BUD_RD:
            begin
                cmd        = CMD_BUD_RD;
                state_next = ST_BUD_WR;
            end
            ST_BUD_WR:
            begin
                cmd        = CMD_BUD_WR;
                state_next = ST_RT_CHK;
            end
            ST_RT_CHK:
            begin
                if (st.rt_done)
                    state_next = ST_DONE;
                else if (st.rt_low)
                    state_next = ST_RT_RD;
                else
                    cmd = CMD_RT_HIGH;
            end
            ST_RT_RD:
            begin
                cmd        = CMD_RT_RD;
                state_next = ST_RT_WR;
            end
            ST_RT_WR:
            begin
                cmd        = CMD_RT_WR;
                state_next = ST_RT_CHK;
            end
            ST_FCLR_RD:
            begin
                cmd        = CMD_FCLR_RD;
                state_next = ST_FCLR_WR;
            end
            ST_FCLR_WR:
            begin
                cmd        = CMD_FCLR_WR;
                state_next = st.fclr_last ? ST_MRG_RD : ST_FCLR_RD;
            end
            ST_MRG_RD:
            begin
                cmd        = CMD_MRG_RD;
                state_next = ST_MRG_WR;
            end
            ST_MRG_WR:
            begin
                cmd        = CMD_MRG_WR;
                state_next = st.pair_any ? ST_MP_RD : ST_MRG_STEP;
            end
            ST_MP_RD:
            begin
                cmd        = CMD_MP_RD;
                state_next = ST_MP_WR;
            end
            ST_MP_WR:
            begin
                cmd        = CMD_MP_WR;
                state_next = ST_MRG_STEP;
            end
            ST_MRG_STEP:
            begin
                if (st.mrg_last && st.mrg_top)
                    state_next = ST_DONE;
                else
                begin
                    cmd        = CMD_MRG_STEP;
                    state_next = ST_MRG_RD;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- hw/rtl/bpa_dp.sv -----
// Buddy page allocator datapath: bitmap memory, request registers, output register.
// Depends on bpa_pkg and buddy_page_allocator_assert.svh.
module bpa_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bpa_pkg::dp_cmd_t              cmd,
    output bpa_pkg::dp_status_t           st,
    input  logic                          in_op,
    input  logic [bpa_pkg::CNT_W-1:0]     in_cnt,
    input  logic [bpa_pkg::PAGE_W-1:0]    in_page,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bpa_pkg::PAGE_W-1:0]    out_start,
    output logic                          out_ok,
    output logic [bpa_pkg::FREE_W-1:0]    out_free
);
    import bpa_pkg::*;
    `include "buddy_page_allocator_assert.svh"

    logic [WORD_W-1:0] mem [MEM_WORDS];
    logic [WORD_W-1:0] rdata_reg;

    logic              op_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [PAGE_W-1:0] last_reg, last_next;
    logic [LVL_W-1:0]  lvl_reg, lvl_next;
    logic [WRD_W-1:0]  wrd_reg, wrd_next;
    logic [PAGE_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]  pages_reg, pages_next;
    logic [31:0]       pmask_reg, pmask_next;
    logic [ADDR_W-1:0] clr_reg;
    logic [FREE_W-1:0] free_reg, free_next;
    logic [PAGE_W-1:0] start_reg, start_next;
    logic              ok_reg, ok_next;
    logic              out_valid_reg;
    logic [PAGE_W-1:0] out_start_reg;
    logic              out_ok_reg;
    logic [FREE_W-1:0] out_free_reg;

    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] wdata;
    logic              rd_en, wr_en;
    logic [POS_W-1:0]  zpos;
    logic [CNT_W-1:0]  half;
    logic [FREE_W-1:0] sum_last;
    logic [PAGE_W-1:0] last_calc;
    logic [FREE_W-1:0] freed;
    logic [FREE_W:0]   free_sum;
    logic [WORD_W-1:0] clr_mask;
    logic [31:0]       pm;
    logic [WORD_W-1:0] pm_exp;
    logic [12:0]       lo, hi;
    logic [WRD_W-1:0]  lvl_words;

    // first free bit of the read word
    always_comb
    begin
        zpos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (!rdata_reg[i])
                zpos = POS_W'(i);
        end
    end

    always_comb
    begin
        sum_last  = FREE_W'(page_reg) + FREE_W'(cnt_reg) - FREE_W'(1);
        last_calc = (sum_last > FREE_W'(TOTAL_PAGES - 1)) ? PAGE_W'(TOTAL_PAGES - 1)
                                                          : sum_last[PAGE_W-1:0];
        freed     = FREE_W'(last_calc) - FREE_W'(page_reg) + FREE_W'(1);
        free_sum  = (FREE_W + 1)'(free_reg) + (FREE_W + 1)'(freed);
        half      = CNT_W'(1) << (lvl_reg - LVL_W'(1));
        lvl_words = WRD_W'(L0_WORDS >> lvl_reg);
        lo        = 13'((page_reg >> lvl_reg) >> 1);
        hi        = 13'((last_reg >> lvl_reg) >> 1);
        for (int b = 0; b < WORD_W; b++)
            clr_mask[b] = ({wrd_reg, POS_W'(b)} >= page_reg)
                       && ({wrd_reg, POS_W'(b)} <= last_reg);
        for (int t = 0; t < 32; t++)
        begin
            pm[t] = !rdata_reg[2*t] && !rdata_reg[2*t+1]
                 && ({wrd_reg, 5'(t)} >= lo) && ({wrd_reg, 5'(t)} <= hi);
            pm_exp[2*t]   = pm[t];
            pm_exp[2*t+1] = pm[t];
        end
    end

    // memory address and write data per command
    always_comb
    begin
        addr  = '0;
        wdata = rdata_reg;
        rd_en = 1'b0;
        wr_en = 1'b0;
        unique case (cmd)
            CMD_CLEAR:
            begin
                addr  = clr_reg;
                wdata = (clr_reg >= lvl_base(LVL_W'(LEVELS - 1))) ? '0 : '1;
                wr_en = 1'b1;
            end
            CMD_SCAN_RD, CMD_FOUND, CMD_MRG_RD, CMD_MRG_WR:
            begin
                addr  = lvl_base(lvl_reg) + ADDR_W'(wrd_reg);
                rd_en = (cmd == CMD_SCAN_RD) || (cmd == CMD_MRG_RD);
                wr_en = (cmd == CMD_FOUND) || (cmd == CMD_MRG_WR);
                wdata = (cmd == CMD_FOUND) ? (rdata_reg | (WORD_W'(1) << zpos))
                                           : (rdata_reg | pm_exp);
            end
            CMD_PAR_RD, CMD_PAR_SET:
            begin
                addr  = lvl_base(lvl_reg + LVL_W'(1)) + ADDR_W'(idx_reg[PAGE_W-1:7]);
                rd_en = (cmd == CMD_PAR_RD);
                wr_en = (cmd == CMD_PAR_SET);
                wdata = rdata_reg | (WORD_W'(1) << idx_reg[6:1]);
            end
            CMD_BUD_RD, CMD_BUD_WR:
            begin
                addr  = lvl_base(lvl_reg) + ADDR_W'(idx_reg[PAGE_W-1:6]);
                rd_en = (cmd == CMD_BUD_RD);
                wr_en = (cmd == CMD_BUD_WR);
                wdata = rdata_reg & ~(WORD_W'(1) << {idx_reg[5:1], ~idx_reg[0]});
            end
            CMD_RT_RD, CMD_RT_WR:
            begin
                addr  = lvl_base(lvl_reg - LVL_W'(1)) + ADDR_W'(idx_reg[12:5]);
                rd_en = (cmd == CMD_RT_RD);
                wr_en = (cmd == CMD_RT_WR);
                wdata = rdata_reg & ~(WORD_W'(1) << {idx_reg[4:0], 1'b1});
            end
            CMD_FCLR_RD, CMD_FCLR_WR:
            begin
                addr  = ADDR_W'(wrd_reg);
                rd_en = (cmd == CMD_FCLR_RD);
                wr_en = (cmd == CMD_FCLR_WR);
                wdata = rdata_reg & ~clr_mask;
            end
            CMD_MP_RD, CMD_MP_WR:
            begin
                addr  = lvl_base(lvl_reg + LVL_W'(1)) + ADDR_W'(wrd_reg[WRD_W-1:1]);
                rd_en = (cmd == CMD_MP_RD);
                wr_en = (cmd == CMD_MP_WR);
                wdata = rdata_reg & ~(wrd_reg[0] ? {pmask_reg, 32'b0} : {32'b0, pmask_reg});
            end
            default:
                rd_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[addr] <= wdata;
        if (rd_en)
            rdata_reg <= mem[addr];
    end

    // request register updates
    always_comb
    begin
        last_next  = last_reg;
        lvl_next   = lvl_reg;
        wrd_next   = wrd_reg;
        idx_next   = idx_reg;
        pages_next = pages_reg;
        pmask_next = pmask_reg;
        free_next  = free_reg;
        start_next = start_reg;
        ok_next    = ok_reg;
        unique case (cmd)
            CMD_START:
            begin
                pages_next = cnt_reg;
                start_next = '0;
                if (op_reg)
                begin
                    lvl_next  = '0;
                    wrd_next  = page_reg[PAGE_W-1:POS_W];
                    last_next = last_calc;
                    ok_next   = 1'b1;
                    free_next = (free_sum > (FREE_W + 1)'(TOTAL_PAGES))
                              ? FREE_W'(TOTAL_PAGES) : free_sum[FREE_W-1:0];
                end
                else
                begin
                    lvl_next = ceil_log2(cnt_reg);
                    wrd_next = '0;
                    ok_next  = 1'b0;
                end
            end
            CMD_FAIL:
            begin
                ok_next    = 1'b0;
                start_next = '0;
            end
            CMD_SCAN_NEXT:
            begin
                if (st.last_word)
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                    wrd_next = '0;
                end
                else
                    wrd_next = wrd_reg + WRD_W'(1);
            end
            CMD_FOUND:
            begin
                idx_next   = {wrd_reg, zpos};
                start_next = PAGE_W'({wrd_reg, zpos} << lvl_reg);
                ok_next    = 1'b1;
                free_next  = (free_reg >= FREE_W'(cnt_reg)) ? free_reg - FREE_W'(cnt_reg) : '0;
            end
            CMD_RT_HIGH:
            begin
                pages_next = pages_reg - half;
                idx_next   = {idx_reg[PAGE_W-2:0], 1'b1};
                lvl_next   = lvl_reg - LVL_W'(1);
            end
            CMD_RT_WR:
            begin
                idx_next = {idx_reg[PAGE_W-2:0], 1'b0};
                lvl_next = lvl_reg - LVL_W'(1);
            end
            CMD_FCLR_WR:
                wrd_next = st.fclr_last ? page_reg[PAGE_W-1:POS_W] : wrd_reg + WRD_W'(1);
            CMD_MRG_WR:
                pmask_next = pm;
            CMD_MRG_STEP:
            begin
                if (st.mrg_last)
                begin
                    lvl_next = lvl_reg + LVL_W'(1);
                    wrd_next = WRD_W'((page_reg >> (lvl_reg + LVL_W'(1))) >> POS_W);
                end
                else
                    wrd_next = wrd_reg + WRD_W'(1);
            end
            default:
                lvl_next = lvl_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_LOAD)
        begin
            op_reg   <= in_op;
            cnt_reg  <= in_cnt;
            page_reg <= in_page;
        end
        last_reg  <= last_next;
        wrd_reg   <= wrd_next;
        idx_reg   <= idx_next;
        pages_reg <= pages_next;
        pmask_reg <= pmask_next;
        start_reg <= start_next;
        ok_reg    <= ok_next;
        if (cmd == CMD_OUT)
        begin
            out_start_reg <= start_reg;
            out_ok_reg    <= ok_reg;
            out_free_reg  <= free_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            lvl_reg       <= '0;
            free_reg      <= FREE_W'(TOTAL_PAGES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lvl_reg  <= lvl_next;
            free_reg <= free_next;
            if (cmd == CMD_CLEAR)
                clr_reg <= clr_reg + ADDR_W'(1);
            if (cmd == CMD_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_comb
    begin
        st.clr_last  = (clr_reg == ADDR_W'(MEM_WORDS - 1));
        st.zero_cnt  = (cnt_reg == '0);
        st.too_big   = !op_reg && (cnt_reg > CNT_W'(MAX_BLOCK));
        st.is_free   = op_reg;
        st.word_full = &rdata_reg;
        st.last_word = (wrd_reg == lvl_words - WRD_W'(1));
        st.top_lvl   = (lvl_reg == LVL_W'(LEVELS - 1));
        st.par_bit   = rdata_reg[idx_reg[6:1]];
        st.rt_done   = (lvl_reg == '0) || (pages_reg == (CNT_W'(1) << lvl_reg));
        st.rt_low    = (pages_reg <= half);
        st.fclr_last = (wrd_reg == last_reg[PAGE_W-1:POS_W]);
        st.pair_any  = |pm;
        st.mrg_last  = (wrd_reg == WRD_W'((last_reg >> lvl_reg) >> POS_W));
        st.mrg_top   = (lvl_reg == LVL_W'(LEVELS - 2));
        st.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_start = out_start_reg;
    assign out_ok    = out_ok_reg;
    assign out_free  = out_free_reg;

    `BPA_ASSERT_IMP(a_free_bound, clk, rst_n, 1'b1, free_reg <= FREE_W'(TOTAL_PAGES), "free count over total")
    `BPA_ASSERT_IMP(a_wr_range, clk, rst_n, wr_en, addr < ADDR_W'(MEM_WORDS), "bitmap write out of range")
    `BPA_ASSERT_NXT(a_found_ok, clk, rst_n, cmd == CMD_FOUND, ok_reg, "allocation found but not marked ok")
    `BPA_ASSERT_IMP(a_lvl_range, clk, rst_n, 1'b1, lvl_reg < LVL_W'(LEVELS), "level index out of range")

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking regression for buddy_page_allocator: directed table, then random
// allocate/free traffic, each result compared with a bitmap-level behavioral model.
// Depends on bpa_pkg and the buddy_page_allocator RTL.
module tb_top;
    import bpa_pkg::*;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam int   MAP_BITS = 2 * TOTAL_PAGES;
    localparam longint CYCLE_LIMIT = 64'd12_000_000;

    typedef struct packed {
        logic [PAGE_W-1:0] start_page;
        logic              ok;
        logic [FREE_W-1:0] free_pages;
    } alloc_result_t;

    typedef struct {
        logic              op;
        logic [CNT_W-1:0]  cnt;
        logic [PAGE_W-1:0] page;
        logic              has_exp;   // typed-in expectation present
        alloc_result_t     exp;
    } req_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // page_count[6:0], page_number[20:7], zero pad
    logic        s_tuser;   // operation
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // start_page[13:0], free_pages[28:14], zero pad
    logic        m_tuser;   // ok

    // model state: one flat bitmap, level k at offset TOTAL_PAGES*2 - (TOTAL_PAGES*2 >> k)
    logic        bitmap [MAP_BITS];
    int unsigned free_cnt;

    alloc_result_t pending_q[$];
    int     errors;
    longint cycles;
    bit     quiet;      // no idling in the last part of the run
    int     results_seen;

    buddy_page_allocator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ---------------- behavioral model ----------------
    function automatic int unsigned level_len(int unsigned k);
        return TOTAL_PAGES >> k;
    endfunction

    function automatic int unsigned level_off(int unsigned k);
        return MAP_BITS - (MAP_BITS >> k);
    endfunction

    // out-of-range bits read as in use
    function automatic bit map_used(int unsigned k, int unsigned idx);
        if (k >= LEVELS || idx >= level_len(k))
            return 1'b1;
        return bitmap[level_off(k) + idx];
    endfunction

    function automatic void map_set(int unsigned k, int unsigned idx, bit v);
        if (k < LEVELS && idx < level_len(k))
            bitmap[level_off(k) + idx] = v;
    endfunction

    function automatic void map_reset();
        for (int i = 0; i < MAP_BITS; i++)
            bitmap[i] = 1'b1;
        for (int unsigned j = 0; j < level_len(LEVELS - 1); j++)
            map_set(LEVELS - 1, j, 1'b0);
        free_cnt = TOTAL_PAGES;
    endfunction

    // hand the unneeded tail of a fresh block back to the lower levels
    function automatic void give_back_tail(int unsigned pages, int unsigned lvl,
                                           int unsigned idx);
        int unsigned half;
        while (lvl > 0 && pages != (1 << lvl))
        begin
            half = 1 << (lvl - 1);
            if (pages <= half)
            begin
                map_set(lvl - 1, 2 * idx + 1, 1'b0);
                idx = 2 * idx;
            end
            else
            begin
                pages -= half;
                idx = 2 * idx + 1;
            end
            lvl--;
        end
    endfunction

    function automatic alloc_result_t predict_request(logic op, logic [CNT_W-1:0] cnt,
                                                      logic [PAGE_W-1:0] page);
        alloc_result_t r;
        int unsigned n, l, last, tally, lo, hi;
        bit done;
        r = '0;
        n = cnt;
        done = 1'b0;
        if (op == OP_ALLOC)
        begin
            if (n != 0)
            begin
                l = 0;
                while ((1 << l) < n)
                    l++;
                if (l <= LEVELS - 1)
                begin
                    for (int unsigned i = l; i < LEVELS && !done; i++)
                    begin
                        for (int unsigned j = 0; j < level_len(i) && !done; j++)
                        begin
                            if (!map_used(i, j))
                            begin
                                map_set(i, j, 1'b1);
                                if (i != LEVELS - 1 && !map_used(i + 1, j >> 1))
                                begin
                                    map_set(i + 1, j >> 1, 1'b1);
                                    map_set(i, j ^ 1, 1'b0);
                                end
                                give_back_tail(n, i, j);
                                free_cnt = (free_cnt >= n) ? free_cnt - n : 0;
                                r.start_page = PAGE_W'(j << i);
                                done = 1'b1;
                            end
                        end
                    end
                end
            end
        end
        else if (n != 0 && page < TOTAL_PAGES)
        begin
            done = 1'b1;
            last = page + n - 1;
            if (last >= TOTAL_PAGES)
                last = TOTAL_PAGES - 1;
            tally = 0;
            for (int unsigned i = page; i <= last; i++)
            begin
                map_set(0, i, 1'b0);
                tally++;
            end
            // merge free buddy pairs upward over the touched span
            for (int unsigned k = 0; k + 1 < LEVELS; k++)
            begin
                lo = (page >> k) >> 1;
                hi = (last >> k) >> 1;
                for (int unsigned q = lo; q <= hi; q++)
                begin
                    if (!map_used(k, 2 * q) && !map_used(k, 2 * q + 1))
                    begin
                        map_set(k + 1, q, 1'b0);
                        map_set(k, 2 * q, 1'b1);
                        map_set(k, 2 * q + 1, 1'b1);
                    end
                end
            end
            free_cnt += tally;
            if (free_cnt > TOTAL_PAGES)
                free_cnt = TOTAL_PAGES;
        end
        r.ok = done;
        if (!done)
            r.start_page = '0;
        r.free_pages = FREE_W'(free_cnt);
        return r;
    endfunction

    // ---------------- request side ----------------
    // valid stays up after an accept unless an idle burst follows
    task automatic send_request(input req_row_t row);
        alloc_result_t want;
        want = predict_request(row.op, row.cnt, row.page);
        if (row.has_exp && want != row.exp)
        begin
            $display("%0t table row disagrees with model: expected %h actual %h",
                     $time, row.exp, want);
            errors++;
        end
        pending_q.push_back(want);
        // idle burst before the request
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.op;
        s_tdata  <= {3'b000, row.page, row.cnt};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    function automatic req_row_t mk(logic op, int cnt, int page, bit has_exp = 0,
                                    int sp = 0, bit ok = 0, int fp = 0);
        req_row_t r;
        r.op = op;
        r.cnt = CNT_W'(cnt);
        r.page = PAGE_W'(page);
        r.has_exp = has_exp;
        r.exp.start_page = PAGE_W'(sp);
        r.exp.ok = ok;
        r.exp.free_pages = FREE_W'(fp);
        return r;
    endfunction

    // ---------------- result side ----------------
    initial
    begin
        alloc_result_t want;
        alloc_result_t got;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got.start_page = m_tdata[13:0];
                got.free_pages = m_tdata[28:14];
                got.ok         = m_tuser;
                results_seen++;
                if (pending_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (got.start_page !== want.start_page)
                    begin
                        $display("%0t start_page: expected %0d actual %0d",
                                 $time, want.start_page, got.start_page);
                        errors++;
                    end
                    if (got.ok !== want.ok)
                    begin
                        $display("%0t ok: expected %0d actual %0d", $time, want.ok, got.ok);
                        errors++;
                    end
                    if (got.free_pages !== want.free_pages)
                    begin
                        $display("%0t free_pages: expected %0d actual %0d",
                                 $time, want.free_pages, got.free_pages);
                        errors++;
                    end
                end
            end
            // occasional stall bursts on m_tready
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
            m_tready <= 1'b1;
        end
    end

    // run watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("buddy_page_allocator regression: fail");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    initial
    begin
        req_row_t table_rows[$];
        req_row_t row;
        int unsigned held_start [$];
        int unsigned held_len [$];
        int idx;
        int pick;
        alloc_result_t peek;

        errors = 0;
        results_seen = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = OP_ALLOC;
        map_reset();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: expectations typed in where obvious from reset state
        table_rows.push_back(mk(OP_ALLOC, 0, 0, 1, 0, 0, 16384));      // zero count
        table_rows.push_back(mk(OP_FREE, 0, 5, 1, 0, 0, 16384));       // zero-count free
        table_rows.push_back(mk(OP_ALLOC, 65, 0, 1, 0, 0, 16384));     // too large
        table_rows.push_back(mk(OP_ALLOC, 127, 16383, 1, 0, 0, 16384));
        table_rows.push_back(mk(OP_ALLOC, 64, 0, 1, 0, 1, 16320));     // whole top block
        table_rows.push_back(mk(OP_ALLOC, 1, 0, 1, 64, 1, 16319));
        table_rows.push_back(mk(OP_ALLOC, 3, 0));                      // tail release
        table_rows.push_back(mk(OP_ALLOC, 33, 0));
        table_rows.push_back(mk(OP_ALLOC, 2, 0));
        table_rows.push_back(mk(OP_FREE, 1, 0));                       // page zero
        table_rows.push_back(mk(OP_FREE, 64, 0));
        table_rows.push_back(mk(OP_FREE, 1, 64));
        table_rows.push_back(mk(OP_FREE, 10, 16380));                  // tail clipped
        table_rows.push_back(mk(OP_FREE, 127, 16383));
        table_rows.push_back(mk(OP_FREE, 5, 16384 - 1));
        table_rows.push_back(mk(OP_FREE, 3, 0));                       // double free
        table_rows.push_back(mk(OP_ALLOC, 1, 16383));
        table_rows.push_back(mk(OP_ALLOC, 63, 0));
        table_rows.push_back(mk(OP_FREE, 127, 7000));
        table_rows.push_back(mk(OP_FREE, 100, 64));
        table_rows.push_back(mk(OP_FREE, 64, 128));

        @(posedge clk);
        foreach (table_rows[i])
            send_request(table_rows[i]);

        // random: mostly alloc / matched free pairs, some noise and misuse
        for (int it = 0; it < 1800; it++)
        begin
            if (it > 1600)
                quiet = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                // rarely a big request, mostly small
                row = mk(OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(33, 127)
                                                                : $urandom_range(1, 32), 0);
                row.page = PAGE_W'($urandom);
                peek = '0;
                send_request(row);
                peek = pending_q[$];
                if (peek.ok)
                begin
                    held_start.push_back(peek.start_page);
                    held_len.push_back(row.cnt);
                end
            end
            else if (pick < 85 && held_start.size() > 0)
            begin
                idx = $urandom_range(0, held_start.size() - 1);
                row = mk(OP_FREE, held_len[idx], held_start[idx]);
                held_start.delete(idx);
                held_len.delete(idx);
                send_request(row);
            end
            else
            begin
                row = mk(1'($urandom_range(0, 1)), $urandom_range(0, 127),
                         $urandom_range(0, 16383));
                if ($urandom_range(0, 3) == 0)
                    row.page = PAGE_W'($urandom_range(16256, 16383));
                send_request(row);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("buddy_page_allocator regression: pass");
        else
            $display("buddy_page_allocator regression: fail");
        $finish;
    end
endmodule

// ----- buddy_page_allocator.f -----
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_dp.sv
hw/rtl/buddy_page_allocator.sv
tb/sv/tb_top.sv
